FILE: rtl/tdci_pkg.sv
// Shared widths, codes, payload and control types of the colour interpolator.
package tdci_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SCAN_W      = $clog2(MAX_ENTRIES + 2);

	localparam int TIME_W    = 12;
	localparam int COLOR_W   = 24;
	localparam int INDEX_W   = 5;
	localparam int ENTRIES_W = 6;
	localparam int CH_W      = 8;
	localparam int NUM_CH    = 3;

	localparam int MIN_W     = TIME_W;
	localparam int DELTA_W   = MIN_W + 1;
	localparam int DIFF_W    = CH_W + 1;
	localparam int PROD_W    = DIFF_W + DELTA_W;
	localparam int NUM_W     = 20;
	localparam int DEN_W     = MIN_W;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = COLOR_W;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_COLOR = 1'd1;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET  = 6'd25;
	localparam logic [COLOR_W-1:0]   FALLBACK_RESET = 24'h0000FF;

	typedef struct packed {
		logic               mode;
		logic [INDEX_W-1:0] entry_index;
		logic [TIME_W-1:0]  entry_time;
		logic [COLOR_W-1:0] entry_color;
		logic [TIME_W-1:0]  query_time;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               in_schedule;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]  tod;
		logic [COLOR_W-1:0] rgb;
	} entry_t;

	typedef struct packed {
		logic write_entry;
		logic start;
		logic scan;
		logic capture;
		logic conv;
		logic mul;
		logic div_step;
		logic load_result;
		logic load_fallback;
	} cmd_t;

	typedef struct packed {
		logic few;
		logic scan_end;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/tdci_ram.sv
// Generic single write port RAM with one registered read port.
module tdci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/tdci_ctrl.sv
// Controller: sequences table writes, the interval scan, blend and division.
module tdci_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_mode,
	output logic           in_ready,
	input  tdci_pkg::sts_t sts,
	output tdci_pkg::cmd_t cmd
);
	import tdci_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CONV,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_FALLBACK
	} state_t;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_mode == MODE_WRITE) begin
						cmd.write_entry = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = sts.few ? ST_FALLBACK : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				priority if (sts.scan_end) begin
					state_d = ST_FALLBACK;
				end else if (sts.hit) begin
					cmd.capture = 1'b1;
					state_d     = ST_CONV;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_FALLBACK: begin
				if (sts.out_free) begin
					cmd.load_fallback = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.write_entry, cmd.start, cmd.scan, cmd.conv, cmd.mul,
			cmd.div_step, cmd.load_result, cmd.load_fallback}))
		else $error("more than one datapath command at once");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_result || cmd.load_fallback) |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> ##NUM_W (state_q == ST_DIV) ##1 (state_q == ST_FIN))
		else $error("division did not run its full length");

endmodule

FILE: rtl/tdci_dp.sv
// Datapath: schedule RAM, scan registers, per-channel blend and serial dividers.
module tdci_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tdci_pkg::cmd_t                     cmd,
	output tdci_pkg::sts_t                     sts,
	input  tdci_pkg::in_item_t                 in_data,
	input  logic                               cfg_valid,
	input  logic [tdci_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tdci_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output tdci_pkg::out_item_t                out_data
);
	import tdci_pkg::*;

	localparam int              RECIP_W  = 11;
	localparam logic [RECIP_W-1:0] HH_RECIP = 11'd1311;
	localparam int              HH_SHIFT = 17;
	localparam int              HH_W     = 6;
	localparam int              RP_W     = TIME_W + RECIP_W;
	localparam int              V_W      = NUM_W + 2;
	localparam logic [CH_W-1:0] CH_MAX   = 8'hFF;

	// hhmm to minutes: hh = floor(t/100) by reciprocal, exact below 4096; t - 40*hh
	function automatic logic [MIN_W-1:0] to_min(input logic [TIME_W-1:0] t);
		logic [RP_W-1:0] p;
		logic [HH_W-1:0] hh;
		p  = RP_W'(t) * RP_W'(HH_RECIP);
		hh = p[HH_SHIFT +: HH_W];
		return MIN_W'(t - (TIME_W'(hh) << 5) - (TIME_W'(hh) << 3));
	endfunction

	logic [ENTRIES_W-1:0] entries_q;
	logic [COLOR_W-1:0]   fallback_q;
	logic [CNT_W-1:0]     n_eff;

	logic [SCAN_W-1:0] rd_idx_q;
	logic [TIME_W-1:0] q_q;
	entry_t            rd_entry, prev_q;
	logic [$bits(entry_t)-1:0] rdata;
	logic              ram_we;

	logic [TIME_W-1:0]  t1_q, t2_q;
	logic [COLOR_W-1:0] c1_q, c2_q;
	logic signed [DELTA_W-1:0] delta_q, span_q;

	logic [NUM_W-1:0] num_q [NUM_CH];
	logic [DEN_W-1:0] rem_q [NUM_CH];
	logic             neg_q [NUM_CH];
	logic [DEN_W-1:0] den_q;
	logic             span_zero_q;

	logic                out_valid_q;
	out_item_t           out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q  <= ENTRIES_RESET;
			fallback_q <= FALLBACK_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENTRIES_IN_USE: entries_q  <= cfg_data[ENTRIES_W-1:0];
				REG_FALLBACK_COLOR: fallback_q <= cfg_data;
			endcase
		end
	end

	assign n_eff = (32'(entries_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(entries_q);

	assign ram_we = cmd.write_entry && (32'(in_data.entry_index) < MAX_ENTRIES);

	tdci_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_sched_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(IDX_W'(in_data.entry_index)),
		.wdata({in_data.entry_time, in_data.entry_color}),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	assign rd_entry = entry_t'(rdata);

	// RAM output holds entry rd_idx_q-1, prev_q holds entry rd_idx_q-2
	assign sts.few      = n_eff < CNT_W'(2);
	assign sts.scan_end = rd_idx_q == (SCAN_W'(n_eff) + SCAN_W'(1));
	assign sts.hit      = (rd_idx_q >= SCAN_W'(2)) && (q_q >= prev_q.tod)
		&& (q_q < rd_entry.tod);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.start) begin
			rd_idx_q <= '0;
		end else if (cmd.scan) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q <= in_data.query_time;
		end
		if (cmd.scan) begin
			prev_q <= rd_entry;
		end
		if (cmd.capture) begin
			t1_q <= prev_q.tod;
			c1_q <= prev_q.rgb;
			t2_q <= rd_entry.tod;
			c2_q <= rd_entry.rgb;
		end
		if (cmd.conv) begin
			delta_q <= $signed({1'b0, to_min(q_q)}) - $signed({1'b0, to_min(t1_q)});
			span_q  <= $signed({1'b0, to_min(t2_q)}) - $signed({1'b0, to_min(t1_q)});
		end
	end

	// blend product, then restoring division of |prod| by |span|, one bit a step
	logic signed [PROD_W-1:0] prod_c [NUM_CH];
	logic        [PROD_W-1:0] mag_c  [NUM_CH];
	logic        [DEN_W:0]    rem_sh [NUM_CH];
	logic        [DEN_W-1:0]  rem_nx [NUM_CH];
	logic                     qbit   [NUM_CH];
	logic signed [DELTA_W-1:0] span_abs;

	always_comb begin
		span_abs = span_q[DELTA_W-1] ? -span_q : span_q;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod_c[ch] = PROD_W'($signed({1'b0, c2_q[ch*CH_W +: CH_W]})
				- $signed({1'b0, c1_q[ch*CH_W +: CH_W]})) * PROD_W'(delta_q);
			mag_c[ch]  = prod_c[ch][PROD_W-1] ? PROD_W'(-prod_c[ch]) : PROD_W'(prod_c[ch]);
			rem_sh[ch] = {rem_q[ch], num_q[ch][NUM_W-1]};
			qbit[ch]   = rem_sh[ch] >= {1'b0, den_q};
			rem_nx[ch] = qbit[ch] ? DEN_W'(rem_sh[ch] - {1'b0, den_q}) : DEN_W'(rem_sh[ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			den_q       <= DEN_W'(span_abs);
			span_zero_q <= span_q == '0;
		end
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (cmd.mul) begin
				num_q[ch] <= mag_c[ch][NUM_W-1:0];
				rem_q[ch] <= '0;
				neg_q[ch] <= prod_c[ch][PROD_W-1] ^ span_q[DELTA_W-1];
			end else if (cmd.div_step) begin
				num_q[ch] <= {num_q[ch][NUM_W-2:0], qbit[ch]};
				rem_q[ch] <= rem_nx[ch];
			end
		end
	end

	// add the signed quotient to the first colour and clamp to a channel; a zero span keeps the first colour
	logic signed [V_W-1:0] quo_s [NUM_CH];
	logic signed [V_W-1:0] v_s   [NUM_CH];
	logic [COLOR_W-1:0]    blend_rgb;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			quo_s[ch] = neg_q[ch] ? -$signed(V_W'(num_q[ch])) : $signed(V_W'(num_q[ch]));
			v_s[ch]   = $signed(V_W'(c1_q[ch*CH_W +: CH_W])) + quo_s[ch];
			priority if (span_zero_q) begin
				blend_rgb[ch*CH_W +: CH_W] = c1_q[ch*CH_W +: CH_W];
			end else if (v_s[ch] < 0) begin
				blend_rgb[ch*CH_W +: CH_W] = '0;
			end else if (v_s[ch] > $signed(V_W'(CH_MAX))) begin
				blend_rgb[ch*CH_W +: CH_W] = CH_MAX;
			end else begin
				blend_rgb[ch*CH_W +: CH_W] = v_s[ch][CH_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result || cmd.load_fallback) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_q.color       <= blend_rgb;
			out_q.in_schedule <= 1'b1;
		end else if (cmd.load_fallback) begin
			out_q.color       <= fallback_q;
			out_q.in_schedule <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (rd_idx_q <= (SCAN_W'(n_eff) + SCAN_W'(1))))
		else $error("scan ran past the entries in use");

	a_fallback_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_fallback |=> (out_valid_q && !out_q.in_schedule
			&& out_q.color == fallback_q))
		else $error("fallback request not presented");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (rd_idx_q <= SCAN_W'(n_eff)))
		else $error("interval matched beyond the entries in use");

endmodule

FILE: rtl/time_of_day_color_interpolator_core.sv
// Top level of the time-of-day colour interpolator.
//
// Input channel (in_valid/in_ready/in_data): a request with mode write loads
// one schedule slot (hhmm time, RGB) and gives no result.
// A request with mode query scans slots 0..n-1 in order for the first pair
// with time[i] <= query_time < time[i+1] and returns one result on the output
// channel (out_valid/out_ready/out_data): the blended colour with in_schedule
// set, or the fallback colour with in_schedule clear.
// A query scans the slots with one RAM read a cycle, then converts the times
// to minutes, forms the product, runs the bit-serial division (three channels
// side by side) and loads the result; a miss, or fewer than two slots in use,
// loads the fallback colour instead. The block takes one query at a time; the
// next request is taken once the previous one has reached the output register.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
// slots in use, index 1 the fallback colour; always ready, to be written by
// the user only while idle, which the block itself does not enforce. Reset
// gives 25 slots in use and fallback 0x0000FF; slot contents are undefined
// until written. A stalled receiver holds the result in place, and a
// finished query then waits in front of the output register.
module time_of_day_color_interpolator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tdci_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tdci_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tdci_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tdci_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tdci_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tdci_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_mode (in_data.mode),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tdci_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

FILE: tb/tdci_colour_checker.sv
// Checker for the colour interpolator: models the schedule table and compares every result.
module tdci_colour_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  tdci_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  tdci_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [tdci_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tdci_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tdci_pkg::*;

	logic [TIME_W-1:0]    sched_tod [MAX_ENTRIES];
	logic [COLOR_W-1:0]   sched_rgb [MAX_ENTRIES];
	logic [ENTRIES_W-1:0] slots_used;
	logic [COLOR_W-1:0]   fallback_rgb;
	out_item_t            colours_due [$];
	out_item_t            want;

	function automatic int hhmm_minutes(input logic [TIME_W-1:0] hhmm);
		int v;
		v = int'(hhmm);
		return (v / 100) * 60 + v % 100;
	endfunction

	function automatic out_item_t predict_colour(input logic [TIME_W-1:0] q);
		out_item_t r;
		int n, delta, span, ca, cb, v;
		logic [COLOR_W-1:0] c1, c2;
		n = int'(slots_used);
		if (n > MAX_ENTRIES)
			n = MAX_ENTRIES;
		r.color = fallback_rgb;
		r.in_schedule = 1'b0;
		for (int i = 0; i + 1 < n; i++) begin
			if (q >= sched_tod[i] && q < sched_tod[i+1]) begin
				c1 = sched_rgb[i];
				c2 = sched_rgb[i+1];
				delta = hhmm_minutes(q) - hhmm_minutes(sched_tod[i]);
				span = hhmm_minutes(sched_tod[i+1]) - hhmm_minutes(sched_tod[i]);
				for (int ch = 0; ch < NUM_CH; ch++) begin
					ca = int'(c1[ch*CH_W +: CH_W]);
					cb = int'(c2[ch*CH_W +: CH_W]);
					v = ca;
					// signed int division truncates toward zero
					if (span != 0)
						v = ca + ((cb - ca) * delta) / span;
					if (v < 0)
						v = 0;
					if (v > 255)
						v = 255;
					r.color[ch*CH_W +: CH_W] = v[CH_W-1:0];
				end
				r.in_schedule = 1'b1;
				return r;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used = ENTRIES_RESET;
			fallback_rgb = FALLBACK_RESET;
			colours_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (colours_due.size() == 0) begin
					errors++;
					$error("unexpected result: color %06h in_schedule %0b",
						out_data.color, out_data.in_schedule);
				end else begin
					want = colours_due.pop_front();
					if (out_data.color !== want.color) begin
						errors++;
						$error("color: expected %06h, got %06h", want.color, out_data.color);
					end
					if (out_data.in_schedule !== want.in_schedule) begin
						errors++;
						$error("in_schedule: expected %0b, got %0b",
							want.in_schedule, out_data.in_schedule);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.mode == MODE_QUERY) begin
					colours_due.push_back(predict_colour(in_data.query_time));
				end else if (in_data.entry_index < MAX_ENTRIES) begin
					sched_tod[in_data.entry_index] = in_data.entry_time;
					sched_rgb[in_data.entry_index] = in_data.entry_color;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ENTRIES_IN_USE)
					slots_used = cfg_data[ENTRIES_W-1:0];
				else if (cfg_index == REG_FALLBACK_COLOR)
					fallback_rgb = cfg_data;
			end
			pending = colours_due.size();
		end
	end

endmodule

FILE: tb/time_of_day_color_interpolator_core_tb.sv
// Testbench top for the colour interpolator: stimulus, handshake idling and verdict.
module time_of_day_color_interpolator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tdci_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    results_pending;
	bit                    quiet;
	int                    items_sent;
	logic [TIME_W-1:0]     slot_tod [MAX_ENTRIES];

	time_of_day_color_interpolator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tdci_colour_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (fail_count),
		.pending   (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TIME_W-1:0] to_hhmm(input int m);
		logic [TIME_W-1:0] v;
		v = TIME_W'((m / 60) * 100 + m % 60);
		return v;
	endfunction

	// unused fields get random filler so every bit toggles
	function automatic in_item_t write_req(input int idx, input logic [TIME_W-1:0] tod,
			input logic [COLOR_W-1:0] rgb);
		in_item_t it;
		it.mode = MODE_WRITE;
		it.entry_index = INDEX_W'(idx);
		it.entry_time = tod;
		it.entry_color = rgb;
		it.query_time = TIME_W'($urandom_range(0, 4095));
		return it;
	endfunction

	function automatic in_item_t query_req(input logic [TIME_W-1:0] q);
		in_item_t it;
		it.mode = MODE_QUERY;
		it.entry_index = INDEX_W'($urandom_range(0, 31));
		it.entry_time = TIME_W'($urandom_range(0, 4095));
		it.entry_color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
		it.query_time = q;
		return it;
	endfunction

	task automatic send(input in_item_t it);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (it.mode == MODE_WRITE)
			slot_tod[it.entry_index] = it.entry_time;
		items_sent++;
	endtask

	// sender holds off until every result is back, then lets the block go idle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_pending != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : receiver
		int hold;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					hold = idle_len();
			end
		end
	end

	initial begin : stimulus
		int n, n_eff, load_cnt, r, k, idx;
		logic [TIME_W-1:0] t1, t2, q;
		logic [COLOR_W-1:0] fb;
		int mins [$];
		int ph;

		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ENTRIES_IN_USE;
		cfg_data = '0;
		quiet = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every slot written before the first query
		send(write_req(0, 12'd0, 24'h000000));
		send(write_req(1, 12'd100, 24'hFFFFFF));
		send(write_req(2, 12'd159, 24'h00FF00));
		// 0160 and 0200 both come to 120 minutes: zero span
		send(write_req(3, 12'd160, 24'h123456));
		send(write_req(4, 12'd200, 24'hABCDEF));
		// 0299 is more minutes than 0330: negative span, channels saturate
		send(write_req(5, 12'd299, 24'h10F080));
		send(write_req(6, 12'd330, 24'hF0108F));
		for (int s = 7; s < MAX_ENTRIES - 1; s++)
			send(write_req(s, to_hhmm(240 + (s - 7) * 50),
				COLOR_W'($urandom_range(0, 24'hFFFFFF))));
		send(write_req(MAX_ENTRIES - 1, 12'd2359, 24'hFFFFFF));

		send(query_req(12'd0));
		send(query_req(12'd30));
		send(query_req(12'd99));
		send(query_req(12'd130));
		send(query_req(12'd159));
		send(query_req(12'd170));
		send(query_req(12'd250));
		send(query_req(12'd299));
		send(query_req(12'd300));
		send(query_req(12'd310));
		send(query_req(12'd2359));
		send(query_req(12'd4095));
		settle();
		set_reg(REG_ENTRIES_IN_USE, 24'd32);
		set_reg(REG_FALLBACK_COLOR, 24'hFFFFFF);
		send(query_req(12'd2330));
		send(query_req(12'd2359));
		settle();
		set_reg(REG_ENTRIES_IN_USE, 24'd63);
		send(query_req(12'd2330));
		settle();
		set_reg(REG_ENTRIES_IN_USE, 24'd0);
		send(query_req(12'd130));
		settle();
		set_reg(REG_ENTRIES_IN_USE, 24'd1);
		send(query_req(12'd130));
		settle();
		set_reg(REG_ENTRIES_IN_USE, 24'd2);
		set_reg(REG_FALLBACK_COLOR, 24'h000000);
		send(query_req(12'd30));
		send(query_req(12'd130));
		send(query_req(12'd4095));

		ph = 0;
		while (items_sent < 1150) begin
			settle();
			r = $urandom_range(0, 9);
			case (r)
				0: n = 0;
				1: n = 1;
				2: n = 2;
				3: n = 63;
				4: n = 32;
				default: n = $urandom_range(3, 32);
			endcase
			r = $urandom_range(0, 5);
			fb = (r == 0) ? 24'h000000 : (r == 1) ? 24'hFFFFFF
				: COLOR_W'($urandom_range(0, 24'hFFFFFF));
			set_reg(REG_ENTRIES_IN_USE, CFG_DATA_W'(n));
			set_reg(REG_FALLBACK_COLOR, fb);
			quiet = ($urandom_range(0, 3) == 0);
			n_eff = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
			load_cnt = (n_eff < 2) ? 4 : n_eff;

			// mostly ascending schedules so queries land in intervals
			mins.delete();
			for (int j = 0; j < load_cnt; j++)
				mins.push_back($urandom_range(0, 1439));
			mins.sort();
			for (int j = 0; j < load_cnt; j++) begin
				if (ph % 5 == 4)
					t1 = TIME_W'($urandom_range(0, 4095));
				else
					t1 = to_hhmm(mins[j]);
				if ($urandom_range(0, 11) == 0 && t1 % 100 < 40)
					t1 = t1 + TIME_W'(60);
				send(write_req(j, t1, COLOR_W'($urandom_range(0, 24'hFFFFFF))));
			end

			for (int j = 0; j < 90; j++) begin
				if (j == 45 && ph % 3 == 1)
					settle();
				r = $urandom_range(0, 99);
				if (r < 20) begin
					idx = $urandom_range(0, 31);
					t1 = ($urandom_range(0, 1) == 0) ? slot_tod[idx]
						: TIME_W'($urandom_range(0, 4095));
					send(write_req(idx, t1, COLOR_W'($urandom_range(0, 24'hFFFFFF))));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 70 && n_eff >= 2) begin
						k = $urandom_range(0, n_eff - 2);
						t1 = slot_tod[k];
						t2 = slot_tod[k+1];
						q = (t2 > t1) ? TIME_W'($urandom_range(t1, t2 - 1)) : t1;
					end else if (r < 80) begin
						q = slot_tod[$urandom_range(0, 31)];
					end else if (r < 93) begin
						q = to_hhmm($urandom_range(0, 1439));
					end else begin
						q = TIME_W'($urandom_range(0, 4095));
					end
					send(query_req(q));
				end
			end
			ph++;
		end

		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
